>>> hdl/gbn_pkg.sv
// Package for the go-back-n sender window: constants, codes, item types and
// the command/status structs between controller and datapath.
// No dependencies.
package gbn_pkg;

	// Sequence space and field widths (fixed by the item fields)
	localparam int SEQ_SPACE   = 16;
	localparam int SEQ_W       = 4;
	localparam int MAX_PAYLOAD = 128;
	localparam int MAX_RESULTS = 15;
	localparam int LEN_W       = 8;
	localparam int TAG_W       = 16;
	localparam int TICKS_W     = 16;
	localparam int WIN_W       = 4;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 16;
	localparam int CNT_W       = 4;

	// Register reset values
	localparam logic [WIN_W-1:0]   RESET_WINDOW = WIN_W'(4);
	localparam logic [TICKS_W-1:0] RESET_TICKS  = TICKS_W'(500);

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 1'b1;

	// Input operations
	localparam logic [1:0] OP_SEND    = 2'd0;
	localparam logic [1:0] OP_ACK     = 2'd1;
	localparam logic [1:0] OP_TIMEOUT = 2'd2;

	// Result actions
	localparam logic [2:0] ACT_NONE    = 3'd0;
	localparam logic [2:0] ACT_SEND    = 3'd1;
	localparam logic [2:0] ACT_RETX    = 3'd2;
	localparam logic [2:0] ACT_ACK     = 3'd3;
	localparam logic [2:0] ACT_REFUSED = 3'd4;

	// Timer commands
	localparam logic [1:0] TMR_NONE  = 2'd0;
	localparam logic [1:0] TMR_START = 2'd1;
	localparam logic [1:0] TMR_STOP  = 2'd2;

	typedef struct packed {
		logic [1:0]       op;
		logic [LEN_W-1:0] msg_len;
		logic [TAG_W-1:0] msg_tag;
		logic [SEQ_W-1:0] ack_seq;
		logic             ack_ok;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         action;
		logic [SEQ_W-1:0]   seq;
		logic [LEN_W-1:0]   length;
		logic [TAG_W-1:0]   tag;
		logic [1:0]         timer_cmd;
		logic [TICKS_W-1:0] timer_ticks;
		logic               last;
	} out_item_t;

	// Descriptor held per slot
	typedef struct packed {
		logic [LEN_W-1:0] length;
		logic [TAG_W-1:0] tag;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

	// Controller to datapath
	typedef struct packed {
		logic accept;     // input transfer this cycle
		logic start_retx; // accepted timeout with slots outstanding
		logic emit;       // load next retransmission into the output register
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_free;   // output register empty or being drained
		logic retx_req;   // presented item is a timeout with slots outstanding
		logic retx_last;  // retransmission being emitted is the final one
	} dp_status_t;

endpackage

>>> hdl/gbn_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module gbn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/gbn_ctrl.sv
// Controller for the go-back-n sender window: idle / retransmit sequencing.
// Depends on gbn_pkg.
module gbn_ctrl
	import gbn_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RETX = 1'b1;

	logic state_q;
	logic state_d;

	// handshake and commands
	always_comb begin
		in_ready       = 1'b0;
		cmd            = '0;
		state_d        = state_q;
		case (state_q)
			ST_IDLE: begin
				in_ready       = status.out_free;
				cmd.accept     = in_valid && status.out_free;
				cmd.start_retx = cmd.accept && status.retx_req;
				if (cmd.start_retx) begin
					state_d = ST_RETX;
				end
			end
			ST_RETX: begin
				cmd.emit = status.out_free;
				if (status.out_free && status.retx_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// no input is taken while a retransmission burst runs
	a_no_accept_in_retx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RETX |-> !cmd.accept)
		else $error("input accepted during retransmission");

	// a burst is entered only from an accepted timeout
	a_retx_entry: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q) |-> $past(cmd.start_retx))
		else $error("retransmission entered without timeout");

	// emit commands only inside a burst
	a_emit_in_retx: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> state_q == ST_RETX)
		else $error("emit outside retransmission");

endmodule

>>> hdl/gbn_dp.sv
// Datapath for the go-back-n sender window: window pointers, configuration,
// slot descriptor RAM, result formation and output register.
// Depends on gbn_pkg and gbn_ram.
module gbn_dp
	import gbn_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  in_item_t              in_data,
	output out_item_t             out_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  dp_cmd_t               cmd,
	output dp_status_t            status
);

	logic [SEQ_W-1:0]   base_q, next_q, ptr_q;
	logic [WIN_W-1:0]   win_q;
	logic [TICKS_W-1:0] ticks_q;
	logic [CNT_W-1:0]   remain_q;
	logic               first_q;
	out_item_t          out_q;
	logic               out_valid_q;

	logic [SEQ_W-1:0]   outstanding, ack_off, ack_next;
	logic [WIN_W-1:0]   eff_win;
	logic               send_ok, ack_hit, wr_en, rd_en;
	logic [SEQ_W-1:0]   rd_addr;
	slot_t              wr_slot, rd_slot;
	out_item_t          res, retx_res;
	logic               load_direct;

	// window arithmetic; sequence space is a power of two, so wrap is free
	always_comb begin
		outstanding = next_q - base_q;
		// window of zero acts as one; a 4-bit window never exceeds SEQ_SPACE-1
		eff_win     = (win_q == '0) ? WIN_W'(1) : win_q;
		send_ok     = (outstanding < eff_win) && (in_data.msg_len != '0)
		              && (in_data.msg_len <= LEN_W'(MAX_PAYLOAD));
		ack_off     = in_data.ack_seq - base_q;
		ack_hit     = in_data.ack_ok && (ack_off < outstanding);
		ack_next    = in_data.ack_seq + SEQ_W'(1);
	end

	// single-result outcome of the presented item
	always_comb begin
		res      = '0;
		res.last = 1'b1;
		case (in_data.op)
			OP_SEND: begin
				if (send_ok) begin
					res.action = ACT_SEND;
					res.seq    = next_q;
					res.length = in_data.msg_len;
					res.tag    = in_data.msg_tag;
					if (outstanding == '0) begin
						res.timer_cmd   = TMR_START;
						res.timer_ticks = ticks_q;
					end
				end else begin
					res.action = ACT_REFUSED;
				end
			end
			OP_ACK: begin
				if (ack_hit) begin
					res.action = ACT_ACK;
					res.seq    = in_data.ack_seq;
					if (ack_next == next_q) begin
						res.timer_cmd = TMR_STOP;
					end
				end
			end
			default: begin
				res.action = ACT_NONE;
			end
		endcase
	end

	// retransmission from the slot just read
	always_comb begin
		retx_res        = '0;
		retx_res.action = ACT_RETX;
		retx_res.seq    = ptr_q;
		retx_res.length = rd_slot.length;
		retx_res.tag    = rd_slot.tag;
		retx_res.last   = (remain_q == CNT_W'(1));
		if (first_q) begin
			retx_res.timer_cmd   = TMR_START;
			retx_res.timer_ticks = ticks_q;
		end
	end

	// slot RAM ports: write on a stored send, read ahead during a burst
	always_comb begin
		wr_en   = cmd.accept && (in_data.op == OP_SEND) && send_ok;
		wr_slot = '{length: in_data.msg_len, tag: in_data.msg_tag};
		rd_en   = cmd.start_retx || cmd.emit;
		rd_addr = cmd.start_retx ? base_q : ptr_q + SEQ_W'(1);
	end

	gbn_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(SEQ_SPACE)
	) u_slot_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(next_q),
		.wdata(wr_slot),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_slot)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q   <= RESET_WINDOW;
			ticks_q <= RESET_TICKS;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_WINDOW_SIZE:   win_q   <= cfg_data[WIN_W-1:0];
				CFG_TIMEOUT_TICKS: ticks_q <= cfg_data[TICKS_W-1:0];
				default: ;
			endcase
		end
	end

	// window pointers and burst counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			next_q   <= '0;
			ptr_q    <= '0;
			remain_q <= '0;
			first_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				next_q <= next_q + SEQ_W'(1);
			end
			if (cmd.accept && (in_data.op == OP_ACK) && ack_hit) begin
				base_q <= ack_next;
			end
			if (cmd.start_retx) begin
				ptr_q    <= base_q;
				remain_q <= CNT_W'(outstanding);
				first_q  <= 1'b1;
			end else if (cmd.emit) begin
				ptr_q    <= ptr_q + SEQ_W'(1);
				remain_q <= remain_q - CNT_W'(1);
				first_q  <= 1'b0;
			end
		end
	end

	// output register
	assign load_direct = cmd.accept && !cmd.start_retx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_direct || cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_direct) begin
			out_q <= res;
		end else if (cmd.emit) begin
			out_q <= retx_res;
		end
	end

	assign out_data         = out_q;
	assign out_valid        = out_valid_q;
	assign status.out_free  = !out_valid_q || out_ready;
	assign status.retx_req  = (in_data.op == OP_TIMEOUT) && (outstanding != '0);
	assign status.retx_last = (remain_q == CNT_W'(1));

	// a stored send advances the next number by one
	a_send_advances: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> next_q == $past(next_q) + SEQ_W'(1))
		else $error("next sequence number did not advance");

	// a burst never emits with nothing left to send
	a_emit_remaining: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> remain_q != '0)
		else $error("retransmission emitted past the window");

	// only retransmissions can be non-final results
	a_nonlast_is_retx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.last |-> out_q.action == ACT_RETX)
		else $error("non-final result that is not a retransmission");

	// ticks are carried only with a timer start
	a_ticks_with_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_q.timer_cmd != TMR_START) |-> out_q.timer_ticks == '0)
		else $error("timer ticks without start");

endmodule

>>> hdl/go_back_n_sender_window_top.sv
// Top level of the go-back-n sender window: controller, datapath and handshakes.
// Depends on gbn_pkg, gbn_ctrl and gbn_dp.
//
// Use: items arrive on in_valid/in_ready with an in_item_t payload (send
// request, acknowledgement or timer expiry). Results leave on
// out_valid/out_ready as out_item_t; last marks the final result of an item.
// Configuration writes (window size, timeout ticks) use cfg_valid/cfg_ready
// with cfg_index and cfg_data; cfg_ready is always high and writes are meant
// for idle periods only.
// Flow: a send, acknowledgement or idle timeout gives its single result in
// the output register in the cycle after the input transfer; a new item can
// be taken in the same cycle that result is transferred out, so these run at
// one item per cycle while the receiver takes each result. A timeout with n
// slots outstanding gives n retransmissions, each read through the registered
// slot descriptor RAM and then the output register, one per cycle while the
// receiver takes them; no input is taken until the last one is loaded.
// Reset clears the window pointers and loads window 4 and 500 ticks; slot
// descriptors are not cleared. When the receiver stalls, the output register
// holds its result and in_ready stays low until it is taken.
module go_back_n_sender_window_top
	import gbn_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	dp_cmd_t    cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	gbn_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.status  (status),
		.cmd     (cmd)
	);

	gbn_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.out_data (out_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.status   (status)
	);

endmodule
